[rtl/core/rrts_pkg.sv]
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by the controller, datapath, top level and checker.
package rrts_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned TickW   = 8;

  localparam logic [TickW-1:0] QUANTUM_RESET = 8'd10;
  localparam logic [TickW-1:0] TICK_MAX      = 8'hFF;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK        = 3'd0,
    ACT_YIELD       = 3'd1,
    ACT_RUN_PENDING = 3'd2,
    ACT_CREATE      = 3'd3,
    ACT_EXIT        = 3'd4,
    ACT_REAP        = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    SLOT_UNUSED   = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2,
    SLOT_ZOMBIE   = 2'd3
  } slot_e;

  typedef struct packed {
    logic capture;
    logic apply;
  } rrts_cmd_t;

endpackage

[rtl/core/round_robin_task_scheduler_top.sv]
// Top level of the round-robin task scheduler with time quantum.
// Instantiates rrts_ctrl and rrts_datapath; depends on rrts_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   request  | start / busy           | action_i task_id_i entry_present_i alloc_ok_i
//   result   | done_o (one cycle)     | success_o .. halted_o
//   config   | quantum_we_i           | quantum_ticks_i
//
// A request is captured together with its pick/free search, then applied in the apply step.
// The result strobe follows in the next cycle, while a new request is accepted.
// A new request is taken only after the apply step ends, set by the capture/apply sequence.
// Reset is asynchronous; no clearing pass is needed. Results cannot be stalled.
module round_robin_task_scheduler_top
  import rrts_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [ActionW-1:0] action_i,
  input  logic [SlotW-1:0]   task_id_i,
  input  logic               entry_present_i,
  input  logic               alloc_ok_i,
  input  logic               quantum_we_i,
  input  logic [TickW-1:0]   quantum_ticks_i,
  output logic               done_o,
  output logic               success_o,
  output logic [SlotW-1:0]   result_slot_o,
  output logic               switched_o,
  output logic [SlotW-1:0]   current_slot_o,
  output logic [CountW-1:0]  used_count_o,
  output logic [CountW-1:0]  ready_count_o,
  output logic               queried_zombie_o,
  output logic               preempt_flag_o,
  output logic               halted_o
);

  rrts_cmd_t cmd;

  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  rrts_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .task_id_i        (task_id_i),
    .entry_present_i  (entry_present_i),
    .alloc_ok_i       (alloc_ok_i),
    .quantum_we_i     (quantum_we_i),
    .quantum_ticks_i  (quantum_ticks_i),
    .success_o        (success_o),
    .result_slot_o    (result_slot_o),
    .switched_o       (switched_o),
    .current_slot_o   (current_slot_o),
    .used_count_o     (used_count_o),
    .ready_count_o    (ready_count_o),
    .queried_zombie_o (queried_zombie_o),
    .preempt_flag_o   (preempt_flag_o),
    .halted_o         (halted_o)
  );

endmodule

[rtl/core/rrts_ctrl.sv]
// Controller for the task scheduler: request accept, apply step and result strobe.
// Depends on rrts_pkg.
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  output rrts_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } ctrl_state_e;

  ctrl_state_e state_q;
  logic        done_q;

  assign busy          = (state_q == S_APPLY);
  assign done_o        = done_q;
  assign cmd_o.capture = start && !busy;
  assign cmd_o.apply   = (state_q == S_APPLY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/rrts_datapath.sv]
// Datapath for the task scheduler: slot table, round-robin pick, counters, results.
// Depends on rrts_pkg; driven by rrts_ctrl through rrts_cmd_t.
module rrts_datapath
  import rrts_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrts_cmd_t           cmd_i,
  input  logic [ActionW-1:0]  action_i,
  input  logic [SlotW-1:0]    task_id_i,
  input  logic                entry_present_i,
  input  logic                alloc_ok_i,
  input  logic                quantum_we_i,
  input  logic [TickW-1:0]    quantum_ticks_i,
  output logic                success_o,
  output logic [SlotW-1:0]    result_slot_o,
  output logic                switched_o,
  output logic [SlotW-1:0]    current_slot_o,
  output logic [CountW-1:0]   used_count_o,
  output logic [CountW-1:0]   ready_count_o,
  output logic                queried_zombie_o,
  output logic                preempt_flag_o,
  output logic                halted_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

  function automatic logic [IdxW-1:0] lowest_set(input logic [NUM_SLOTS-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = IdxW'(i);
    end
    return r;
  endfunction

  slot_e            slot_q [NUM_SLOTS];
  slot_e            slot_d [NUM_SLOTS];
  logic [IdxW-1:0]  cur_q, cur_d;
  logic [TickW-1:0] ticks_q, ticks_d;
  logic             pend_q, pend_d;
  logic             halt_q, halt_d;
  logic [TickW-1:0] quant_q;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  ready_q, ready_d;

  action_e          act_q;
  logic [SlotW-1:0] tid_q;
  logic             entry_q, alloc_q;
  logic [IdxW-1:0]  nxt_q, free_q;
  logic             nxt_ok_q, free_ok_q;

  logic [NUM_SLOTS-1:0] runnable_v, above_v, below_v, free_v, hi_v, lo_v;
  logic [IdxW-1:0]      nxt_d, free_d;
  logic                 nxt_ok_d, free_ok_d;

  logic             succ_d, sw_d, qz_d;
  logic [IdxW-1:0]  rslot_d;
  logic [IdxW-1:0]  tidx;
  logic             tid_ok;
  slot_e            cur_st;

  logic             succ_q, sw_q, qz_q;
  logic [IdxW-1:0]  rslot_q;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      runnable_v[i] = (slot_q[i] == SLOT_RUNNABLE);
      above_v[i]    = (IdxW'(i) > cur_q);
      below_v[i]    = (IdxW'(i) < cur_q);
      free_v[i]     = (i != 0) && ((slot_q[i] == SLOT_UNUSED) || (slot_q[i] == SLOT_ZOMBIE));
    end
    hi_v      = runnable_v & above_v;
    lo_v      = runnable_v & below_v;
    nxt_ok_d  = (|hi_v) || (|lo_v) || ((cur_q != '0) && (slot_q[0] == SLOT_RUNNING));
    nxt_d     = (|hi_v) ? lowest_set(hi_v) : ((|lo_v) ? lowest_set(lo_v) : '0);
    free_ok_d = |free_v;
    free_d    = lowest_set(free_v);
  end

  assign tidx   = IdxW'(tid_q);
  assign tid_ok = (32'(tid_q) < NUM_SLOTS);
  assign cur_st = slot_q[cur_q];

  always_comb begin
    slot_d  = slot_q;
    cur_d   = cur_q;
    ticks_d = ticks_q;
    pend_d  = pend_q;
    halt_d  = halt_q;
    used_d  = used_q;
    ready_d = ready_q;
    succ_d  = 1'b0;
    sw_d    = 1'b0;
    rslot_d = '0;
    case (act_q)
      ACT_TICK: begin
        if (ticks_q != TICK_MAX) ticks_d = ticks_q + TickW'(1);
        if (ticks_d >= quant_q) pend_d = 1'b1;
      end
      ACT_YIELD, ACT_RUN_PENDING: begin
        if (((act_q == ACT_YIELD) || pend_q) && nxt_ok_q) begin
          if (cur_st == SLOT_RUNNING) slot_d[cur_q] = SLOT_RUNNABLE;
          slot_d[nxt_q] = SLOT_RUNNING;
          cur_d   = nxt_q;
          ticks_d = '0;
          pend_d  = 1'b0;
          halt_d  = 1'b0;
          succ_d  = 1'b1;
          sw_d    = 1'b1;
          rslot_d = nxt_q;
        end
      end
      ACT_CREATE: begin
        if (entry_q && free_ok_q && alloc_q) begin
          slot_d[free_q] = SLOT_RUNNABLE;
          if (slot_q[free_q] == SLOT_UNUSED) used_d = used_q + CntW'(1);
          ready_d = ready_q + CntW'(1);
          succ_d  = 1'b1;
          rslot_d = free_q;
        end
      end
      ACT_EXIT: begin
        if (cur_q != '0) begin
          slot_d[cur_q] = SLOT_ZOMBIE;
          if (cur_st == SLOT_UNUSED) used_d = used_q + CntW'(1);
          if ((cur_st == SLOT_RUNNABLE) || (cur_st == SLOT_RUNNING)) begin
            ready_d = ready_q - CntW'(1);
          end
          if (nxt_ok_q) begin
            slot_d[nxt_q] = SLOT_RUNNING;
            cur_d   = nxt_q;
            ticks_d = '0;
            pend_d  = 1'b0;
            halt_d  = 1'b0;
            succ_d  = 1'b1;
            sw_d    = 1'b1;
            rslot_d = nxt_q;
          end else begin
            halt_d = 1'b1;
          end
        end
      end
      ACT_REAP: begin
        if (tid_ok && (tid_q != '0) && (slot_q[tidx] == SLOT_ZOMBIE)) begin
          slot_d[tidx] = SLOT_UNUSED;
          used_d = used_q - CntW'(1);
          succ_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    qz_d = tid_ok && (slot_d[tidx] == SLOT_ZOMBIE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_q[i] <= (i == 0) ? SLOT_RUNNING : SLOT_UNUSED;
      end
      cur_q   <= '0;
      ticks_q <= '0;
      pend_q  <= 1'b0;
      halt_q  <= 1'b0;
      quant_q <= QUANTUM_RESET;
      used_q  <= CntW'(1);
      ready_q <= CntW'(1);
    end else begin
      if (quantum_we_i) quant_q <= quantum_ticks_i;
      if (cmd_i.apply) begin
        slot_q  <= slot_d;
        cur_q   <= cur_d;
        ticks_q <= ticks_d;
        pend_q  <= pend_d;
        halt_q  <= halt_d;
        used_q  <= used_d;
        ready_q <= ready_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q     <= action_e'(action_i);
      tid_q     <= task_id_i;
      entry_q   <= entry_present_i;
      alloc_q   <= alloc_ok_i;
      nxt_q     <= nxt_d;
      nxt_ok_q  <= nxt_ok_d;
      free_q    <= free_d;
      free_ok_q <= free_ok_d;
    end
    if (cmd_i.apply) begin
      succ_q  <= succ_d;
      sw_q    <= sw_d;
      rslot_q <= rslot_d;
      qz_q    <= qz_d;
    end
  end

  assign success_o        = succ_q;
  assign result_slot_o    = SlotW'(rslot_q);
  assign switched_o       = sw_q;
  assign current_slot_o   = SlotW'(cur_q);
  assign used_count_o     = CountW'(used_q);
  assign ready_count_o    = CountW'(ready_q);
  assign queried_zombie_o = qz_q;
  assign preempt_flag_o   = pend_q;
  assign halted_o         = halt_q;

endmodule

[rtl/core/rrts_checker.sv]
// Port-level checks for the task scheduler top level, attached by bind.
// Depends on rrts_pkg and round_robin_task_scheduler_top.
module rrts_checker
  import rrts_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic              success_o,
  input logic [SlotW-1:0]  result_slot_o,
  input logic              switched_o,
  input logic [SlotW-1:0]  current_slot_o,
  input logic [CountW-1:0] used_count_o,
  input logic [CountW-1:0] ready_count_o
);

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request accept");

  a_done_follows_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing two cycles after request");

  a_done_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe without a completed request");

  a_switch_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && switched_o) |-> (success_o && (result_slot_o == current_slot_o)))
    else $error("switch result does not match current slot");

  a_counts_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (ready_count_o <= used_count_o))
    else $error("ready count exceeds used count");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (.*);

[bench/tb.sv]
// Self-checking bench for round_robin_task_scheduler_top: directed and random scheduler requests.
// Predicts every result from an internal copy of the slot table and checks each one field by field.
// Depends on rrts_pkg and round_robin_task_scheduler_top.
module tb;
  import rrts_pkg::*;

  localparam int Slots = 16;
  localparam logic [ActionW-1:0] ACT_UNDEF_A = 3'd6;
  localparam logic [ActionW-1:0] ACT_UNDEF_B = 3'd7;

  typedef struct packed {
    logic              success;
    logic [SlotW-1:0]  rslot;
    logic              sw;
    logic [SlotW-1:0]  cur;
    logic [CountW-1:0] used;
    logic [CountW-1:0] ready;
    logic              qz;
    logic              pre;
    logic              halt;
  } sched_out_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [ActionW-1:0] action_i = ACT_TICK;
  logic [SlotW-1:0]   task_id_i = '0;
  logic               entry_present_i = 1'b0;
  logic               alloc_ok_i = 1'b0;
  logic               quantum_we_i = 1'b0;
  logic [TickW-1:0]   quantum_ticks_i = '0;
  logic               done_o;
  logic               success_o;
  logic [SlotW-1:0]   result_slot_o;
  logic               switched_o;
  logic [SlotW-1:0]   current_slot_o;
  logic [CountW-1:0]  used_count_o;
  logic [CountW-1:0]  ready_count_o;
  logic               queried_zombie_o;
  logic               preempt_flag_o;
  logic               halted_o;

  slot_e            slot_tbl [Slots];
  logic [SlotW-1:0] cur_slot;
  logic [TickW-1:0] tick_cnt;
  logic             preempt_pend;
  logic             halt_pend;
  logic [TickW-1:0] quantum;

  sched_out_t expected_q [$];
  int n_errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_switches = 0;
  int n_creates = 0;
  bit gaps_on = 1'b1;

  round_robin_task_scheduler_top #(.NUM_SLOTS(Slots)) dut (
    .clk_i, .rst_ni, .start, .busy,
    .action_i, .task_id_i, .entry_present_i, .alloc_ok_i,
    .quantum_we_i, .quantum_ticks_i,
    .done_o, .success_o, .result_slot_o, .switched_o, .current_slot_o,
    .used_count_o, .ready_count_o, .queried_zombie_o, .preempt_flag_o, .halted_o
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void reset_scheduler();
    foreach (slot_tbl[i]) slot_tbl[i] = SLOT_UNUSED;
    slot_tbl[0] = SLOT_RUNNING;
    cur_slot = '0;
    tick_cnt = '0;
    preempt_pend = 1'b0;
    halt_pend = 1'b0;
    quantum = QUANTUM_RESET;
  endfunction

  function automatic bit find_next(output logic [SlotW-1:0] nxt);
    int idx;
    nxt = '0;
    for (int k = 1; k < Slots; k++) begin
      idx = (int'(cur_slot) + k) % Slots;
      if (slot_tbl[idx] == SLOT_RUNNABLE) begin
        nxt = idx[SlotW-1:0];
        return 1'b1;
      end
    end
    if (cur_slot != 0 && (slot_tbl[0] == SLOT_RUNNABLE || slot_tbl[0] == SLOT_RUNNING))
      return 1'b1;
    return 1'b0;
  endfunction

  function automatic void switch_task(logic [SlotW-1:0] nxt);
    cur_slot = nxt;
    slot_tbl[nxt] = SLOT_RUNNING;
    tick_cnt = '0;
    preempt_pend = 1'b0;
    halt_pend = 1'b0;
  endfunction

  function automatic sched_out_t schedule_step(logic [ActionW-1:0] act, logic [SlotW-1:0] tid,
                                               logic entry, logic alloc);
    sched_out_t r;
    logic [SlotW-1:0] nxt;
    int free_slot;
    r = '0;
    case (act)
      ACT_TICK: begin
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= quantum) preempt_pend = 1'b1;
      end
      ACT_YIELD, ACT_RUN_PENDING: begin
        if ((act == ACT_YIELD || preempt_pend) && find_next(nxt)) begin
          if (slot_tbl[cur_slot] == SLOT_RUNNING) slot_tbl[cur_slot] = SLOT_RUNNABLE;
          switch_task(nxt);
          r.success = 1'b1;
          r.rslot = nxt;
          r.sw = 1'b1;
        end
      end
      ACT_CREATE: begin
        free_slot = 0;
        for (int i = Slots - 1; i >= 1; i--)
          if (slot_tbl[i] == SLOT_UNUSED || slot_tbl[i] == SLOT_ZOMBIE) free_slot = i;
        if (entry && alloc && free_slot != 0) begin
          slot_tbl[free_slot] = SLOT_RUNNABLE;
          r.success = 1'b1;
          r.rslot = free_slot[SlotW-1:0];
        end
      end
      ACT_EXIT: begin
        if (cur_slot != 0) begin
          slot_tbl[cur_slot] = SLOT_ZOMBIE;
          if (find_next(nxt)) begin
            switch_task(nxt);
            r.success = 1'b1;
            r.rslot = nxt;
            r.sw = 1'b1;
          end else begin
            halt_pend = 1'b1;
          end
        end
      end
      ACT_REAP: begin
        if (tid != 0 && slot_tbl[tid] == SLOT_ZOMBIE) begin
          slot_tbl[tid] = SLOT_UNUSED;
          r.success = 1'b1;
        end
      end
      default: ;
    endcase
    foreach (slot_tbl[i]) begin
      if (slot_tbl[i] != SLOT_UNUSED) r.used = r.used + 1'b1;
      if (slot_tbl[i] == SLOT_RUNNABLE || slot_tbl[i] == SLOT_RUNNING) r.ready = r.ready + 1'b1;
    end
    r.qz = (slot_tbl[tid] == SLOT_ZOMBIE);
    r.cur = cur_slot;
    r.pre = preempt_pend;
    r.halt = halt_pend;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
             what, got, want, n_results, $time);
    n_errors++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : check_result
    sched_out_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result strobe", 1, 0);
      end else begin
        want = expected_q.pop_front();
        check_field("success", success_o, want.success);
        check_field("result_slot", result_slot_o, want.rslot);
        check_field("switched", switched_o, want.sw);
        check_field("current_slot", current_slot_o, want.cur);
        check_field("used_count", used_count_o, want.used);
        check_field("ready_count", ready_count_o, want.ready);
        check_field("queried_zombie", queried_zombie_o, want.qz);
        check_field("preempt_flag", preempt_flag_o, want.pre);
        check_field("halted", halted_o, want.halt);
      end
    end
  end

  task automatic issue_request(logic [ActionW-1:0] act, logic [SlotW-1:0] tid,
                               logic entry, logic alloc);
    sched_out_t want;
    start <= 1'b1;
    action_i <= act;
    task_id_i <= tid;
    entry_present_i <= entry;
    alloc_ok_i <= alloc;
    do @(posedge clk_i); while (busy);
    want = schedule_step(act, tid, entry, alloc);
    expected_q.push_back(want);
    n_requests++;
    if (want.sw) n_switches++;
    if (act == ACT_CREATE && want.success) n_creates++;
  endtask

  task automatic maybe_pause();
    if (gaps_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send(logic [ActionW-1:0] act, logic [SlotW-1:0] tid,
                      logic entry, logic alloc);
    maybe_pause();
    issue_request(act, tid, entry, alloc);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_quantum(logic [TickW-1:0] q);
    drain();
    quantum_we_i <= 1'b1;
    quantum_ticks_i <= q;
    @(posedge clk_i);
    quantum_we_i <= 1'b0;
    quantum = q;
  endtask

  task automatic test_directed_cases();
    send(ACT_TICK, 4'd15, 1'b0, 1'b0);
    send(ACT_YIELD, 4'd0, 1'b0, 1'b0);
    send(ACT_RUN_PENDING, 4'd0, 1'b1, 1'b1);
    send(ACT_CREATE, 4'd1, 1'b0, 1'b1);
    send(ACT_CREATE, 4'd1, 1'b1, 1'b0);
    send(ACT_CREATE, 4'd1, 1'b1, 1'b1);
    send(ACT_CREATE, 4'd2, 1'b1, 1'b1);
    send(ACT_YIELD, 4'd0, 1'b0, 1'b0);
    send(ACT_EXIT, 4'd1, 1'b0, 1'b0);
    send(ACT_REAP, 4'd0, 1'b0, 1'b0);
    send(ACT_REAP, 4'd2, 1'b0, 1'b0);
    send(ACT_TICK, 4'd1, 1'b0, 1'b0);
    send(ACT_REAP, 4'd1, 1'b0, 1'b0);
    send(ACT_UNDEF_A, 4'd15, 1'b1, 1'b1);
    send(ACT_UNDEF_B, 4'd0, 1'b1, 1'b1);
    send(ACT_YIELD, 4'd0, 1'b0, 1'b0);
    send(ACT_EXIT, 4'd0, 1'b0, 1'b0);
    set_quantum(8'd1);
    send(ACT_RUN_PENDING, 4'd0, 1'b0, 1'b0);
    send(ACT_TICK, 4'd0, 1'b0, 1'b0);
    send(ACT_RUN_PENDING, 4'd0, 1'b0, 1'b0);
    send(ACT_TICK, 4'd0, 1'b0, 1'b0);
    send(ACT_YIELD, 4'd15, 1'b0, 1'b0);
  endtask

  task automatic test_quantum_zero();
    set_quantum(8'd0);
    send(ACT_TICK, 4'd0, 1'b0, 1'b0);
    send(ACT_RUN_PENDING, 4'd0, 1'b0, 1'b0);
    send(ACT_TICK, 4'd3, 1'b0, 1'b0);
  endtask

  task automatic test_full_table();
    repeat (16) send(ACT_CREATE, 4'd0, 1'b1, 1'b1);
    repeat (3) send(ACT_YIELD, 4'd7, 1'b0, 1'b0);
    repeat (4) send(ACT_EXIT, 4'd9, 1'b0, 1'b0);
    send(ACT_CREATE, 4'd0, 1'b1, 1'b1);
    repeat (17) send(ACT_YIELD, 4'd5, 1'b0, 1'b0);
  endtask

  task automatic test_tick_saturation();
    set_quantum(8'd255);
    send(ACT_YIELD, 4'd0, 1'b0, 1'b0);
    repeat (260) send(ACT_TICK, 4'($urandom_range(15)), 1'b0, 1'b0);
    send(ACT_RUN_PENDING, 4'd0, 1'b0, 1'b0);
  endtask

  task automatic run_random_phase(int count, logic [TickW-1:0] q, bit with_gaps);
    logic [ActionW-1:0] act;
    logic [SlotW-1:0] tid;
    logic [SlotW-1:0] zombies [$];
    int pick;
    set_quantum(q);
    gaps_on = with_gaps;
    repeat (count) begin
      pick = $urandom_range(99);
      tid = $urandom_range(15);
      if (pick < 30) act = ACT_TICK;
      else if (pick < 44) act = ACT_YIELD;
      else if (pick < 57) act = ACT_RUN_PENDING;
      else if (pick < 73) act = ACT_CREATE;
      else if (pick < 85) act = ACT_EXIT;
      else if (pick < 97) act = ACT_REAP;
      else act = pick[0] ? ACT_UNDEF_A : ACT_UNDEF_B;
      if (act == ACT_REAP && $urandom_range(99) < 75) begin
        zombies.delete();
        foreach (slot_tbl[i]) if (slot_tbl[i] == SLOT_ZOMBIE) zombies.push_back(i[SlotW-1:0]);
        if (zombies.size() != 0) tid = zombies[$urandom_range(zombies.size() - 1)];
      end
      send(act, tid, $urandom_range(99) < 85, $urandom_range(99) < 85);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_phase(200, 8'd1, 1'b1);
    run_random_phase(200, 8'd255, 1'b0);
    run_random_phase(200, 8'($urandom_range(2, 20)), 1'b1);
    run_random_phase(200, 8'd0, 1'b1);
    run_random_phase(200, 8'($urandom_range(1, 255)), 1'b1);
  endtask

  initial begin
    reset_scheduler();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_quantum_zero();
    test_full_table();
    test_tick_saturation();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d requests and %0d results: %0d task switches, %0d creates.",
             n_requests, n_results, n_switches, n_creates);
    $display("Quantum settings 0, 1, 10, 255 and random; tick saturation and full table.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
